/* sv/b64da_pkg.sv */
package b64da_pkg;

  localparam int NDIG      = 20;  // digits of 2^64 - 1
  localparam int STEP_BITS = 4;   // binary bits folded in per cycle
  localparam int NSTEP     = 64 / STEP_BITS;

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef logic [3:0] bcd_t;
  typedef logic [NDIG-1:0][3:0] digits_t;

  typedef struct packed {
    logic [31:0] value_high;
    logic [31:0] value_low;
  } value_t;

  typedef struct packed {
    logic [5:0] digit_char;
    logic [4:0] digit_count;
    logic       is_last;
  } digit_t;

  // finished conversion handed from the cell row to the emitter
  typedef struct packed {
    digits_t    digits;
    logic [4:0] count;
  } conv_res_t;

endpackage

/* sv/b64da_cell.sv */
module b64da_cell
  import b64da_pkg::*;
(
  input  logic                 clk,
  input  logic                 clear,
  input  logic                 step,
  input  logic [STEP_BITS-1:0] cin,
  output logic [STEP_BITS-1:0] cout,
  output bcd_t                 digit,
  output bcd_t                 digit_next
);

  // Several add-3 / shift steps of double dabble per cycle. cin[s] and
  // cout[s] belong to step s, so the carry wave runs diagonally down the row.
  always_comb begin
    bcd_t d;
    d = digit;
    for (int s = 0; s < STEP_BITS; s++) begin
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      cout[s] = d[3];
      d = {d[2:0], cin[s]};
    end
    digit_next = d;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= '0;
    end else if (step) begin
      digit <= digit_next;
    end
  end

endmodule

/* sv/b64da_emit.sv */
module b64da_emit
  import b64da_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  conv_res_t res,
  output logic      buf_free,
  output logic      digit_valid,
  input  logic      digit_ready,
  output digit_t    digit
);

  digits_t    dbuf;
  logic [4:0] ocnt;
  logic [4:0] optr;
  logic       obusy;
  logic       adv;

  assign adv      = obusy && (!digit_valid || digit_ready);
  // the buffer can be refilled in the cycle its last digit moves out
  assign buf_free = !obusy || (adv && optr == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      obusy       <= 1'b0;
      digit_valid <= 1'b0;
    end else begin
      if (adv) begin
        digit.digit_char  <= ASCII_ZERO + {2'b00, dbuf[optr]};
        digit.digit_count <= ocnt;
        digit.is_last     <= (optr == 5'd0);
        digit_valid       <= 1'b1;
      end else if (digit_ready) begin
        digit_valid <= 1'b0;
      end
      if (load) begin
        dbuf  <= res.digits;
        ocnt  <= res.count;
        optr  <= res.count - 5'd1;
        obusy <= 1'b1;
      end else if (adv) begin
        optr <= optr - 5'd1;
        if (optr == 5'd0) begin
          obusy <= 1'b0;
        end
      end
    end
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit.digit_char >= 6'd48 && digit.digit_char <= 6'd57))
    else $error("digit outside 0..9");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit.digit_count >= 5'd1 && digit.digit_count <= 5'd20))
    else $error("digit count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> buf_free)
    else $error("emitter loaded while still draining");

endmodule

/* sv/binary64_to_decimal_ascii_unit.sv */
// channel | handshake                  | payload
// value   | value_valid / value_ready  | value  (value_high, value_low)
// digit   | digit_valid / digit_ready  | digit  (digit_char, digit_count, is_last)
//
// A row of 20 BCD cells folds in 4 input bits per cycle; the finished digits
// are then handed to the emit buffer once it is free. The emitter sends one
// digit per cycle while digit_ready is high, and the next conversion runs
// while the digits drain.
// rst is synchronous and clears only control state.
// A stalled digit output holds its register; the row keeps converting.
module binary64_to_decimal_ascii_unit
  import b64da_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   value_valid,
  output logic   value_ready,
  input  value_t value,
  output logic   digit_valid,
  input  logic   digit_ready,
  output digit_t digit
);

  logic                              busy;
  logic                              full;
  logic [3:0]                        cnt;
  logic [63:0]                       bin;
  logic [4:0]                        len;
  logic [4:0]                        len_next;
  logic [4:0]                        idx_up;
  logic                              accept;
  logic                              hand;
  logic                              buf_free;
  logic [NDIG:0][STEP_BITS-1:0]      carry;
  digits_t                           digs;
  digits_t                           digs_next;
  logic [31:0]                       nz_pad;
  conv_res_t                         res;

  assign value_ready = !busy && (!full || buf_free);
  assign accept      = value_valid && value_ready;
  assign hand        = full && buf_free;

  // step s takes bin[63-s]
  assign carry[0] = {bin[60], bin[61], bin[62], bin[63]};

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    b64da_cell u_cell (
      .clk        (clk),
      .clear      (accept),
      .step       (busy),
      .cin        (carry[i]),
      .cout       (carry[i+1]),
      .digit      (digs[i]),
      .digit_next (digs_next[i])
    );
    assign nz_pad[i] = |digs_next[i];
  end
  assign nz_pad[31:NDIG] = '0;

  // Each step multiplies the value by 16 and adds at most 15, so the length grows
  // by two digits at most and only the two cells above it need a look.
  assign idx_up   = len + 5'd1;
  assign len_next = nz_pad[idx_up] ? len + 5'd2 :
                    nz_pad[len]    ? idx_up     : len;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      full <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
      full <= 1'b0;
      cnt  <= '0;
      bin  <= {value.value_high, value.value_low};
      len  <= '0;
    end else begin
      if (hand) begin
        full <= 1'b0;
      end
      if (busy) begin
        cnt <= cnt + 4'd1;
        bin <= bin << STEP_BITS;
        len <= len_next;
        if (cnt == 4'(NSTEP - 1)) begin
          busy <= 1'b0;
          full <= 1'b1;
        end
      end
    end
  end

  assign res.digits = digs;
  assign res.count  = (len == 5'd0) ? 5'd1 : len;

  b64da_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (hand),
    .res         (res),
    .buf_free    (buf_free),
    .digit_valid (digit_valid),
    .digit_ready (digit_ready),
    .digit       (digit)
  );

  a_run_hold: assert property (@(posedge clk) disable iff (rst)
    !(busy && full))
    else $error("converter running and holding at once");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    busy |-> carry[NDIG] == '0)
    else $error("carry out of the top digit cell");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && cnt == 4'd0)
    else $error("accepted value did not start a conversion");

endmodule

/* bench/binary64_to_decimal_ascii_unit_test.sv */
module binary64_to_decimal_ascii_unit_test;
  import b64da_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_AT  = 100;  // long receiver hold-off starts near here
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN_AT  = 250;  // sender waits for all digits here
  localparam int QUIET_LEN = 60;   // no idling over the last items
  localparam int SETTLE    = 40;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   value_valid = 1'b0;
  logic   value_ready;
  value_t value = '0;
  logic   digit_valid;
  logic   digit_ready = 1'b0;
  digit_t digit;

  value_t feed_q[$];
  digit_t digits_due[$];

  int sent_count = 0;
  int accepted_count = 0;
  int total_items = 0;
  int quiet_start = 0;
  int mismatches = 0;
  int send_gap = 0;
  int ready_gap = 0;
  int hold_left = 0;
  bit value_taken = 1'b0;
  bit drain_done = 1'b0;
  bit hold_done = 1'b0;

  binary64_to_decimal_ascii_unit dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .digit_valid (digit_valid),
    .digit_ready (digit_ready),
    .digit       (digit)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] pow10(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  // expected ASCII digits of one value, most significant first
  function automatic void expand_decimal(input value_t v);
    logic [63:0] rest;
    logic [3:0]  rev[NDIG];
    int          n;
    digit_t      d;
    rest = {v.value_high, v.value_low};
    n = 0;
    do begin
      rev[n] = 4'(rest % 64'd10);
      rest = rest / 64'd10;
      n++;
    end while (rest != 64'd0 && n < NDIG);
    for (int k = 0; k < n; k++) begin
      d.digit_char  = ASCII_ZERO + 6'(rev[n-1-k]);
      d.digit_count = 5'(n);
      d.is_last     = (k == n - 1);
      digits_due.push_back(d);
    end
  endfunction

  function automatic bit idling_allowed();
    return sent_count < quiet_start && ((sent_count / 50) % 4) != 3;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else if (!value_valid || value_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        value_valid <= 1'b0;
      end else if (sent_count == DRAIN_AT && !drain_done) begin
        value_valid <= 1'b0;
        if (digits_due.size() == 0) drain_done = 1'b1;
      end else if (feed_q.size() == 0) begin
        value_valid <= 1'b0;
      end else if (idling_allowed() && hold_left == 0 && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(0, 12);
        value_valid <= 1'b0;
      end else begin
        value <= feed_q.pop_front();
        value_valid <= 1'b1;
        sent_count++;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      digit_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      digit_ready <= 1'b0;
    end else if (!hold_done && sent_count >= STALL_AT) begin
      // long hold-off while the sender keeps offering: fills the unit
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      digit_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      digit_ready <= 1'b0;
    end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
      ready_gap = $urandom_range(0, 12);
      digit_ready <= 1'b0;
    end else begin
      digit_ready <= 1'b1;
    end
  end

  // monitor: check digit transfers, then predict from value transfers
  always @(posedge clk) begin
    digit_t want;
    value_taken = 1'b0;
    if (!rst) begin
      if (digit_valid === 1'b1 && digit_ready) begin
        if (digits_due.size() == 0) begin
          report_mismatch($sformatf("unexpected digit %h", digit));
        end else begin
          want = digits_due.pop_front();
          if (digit.digit_char !== want.digit_char)
            report_mismatch($sformatf("digit_char got %0d want %0d",
                                      digit.digit_char, want.digit_char));
          if (digit.digit_count !== want.digit_count)
            report_mismatch($sformatf("digit_count got %0d want %0d",
                                      digit.digit_count, want.digit_count));
          if (digit.is_last !== want.is_last)
            report_mismatch($sformatf("is_last got %0b want %0b",
                                      digit.is_last, want.is_last));
        end
      end
      if (value_valid && value_ready === 1'b1) begin
        value_taken = 1'b1;
        accepted_count++;
        expand_decimal(value);
      end
    end
  end

  initial begin
    logic [63:0] r;
    feed_q.push_back(value_t'(64'd0));
    feed_q.push_back(value_t'(64'd1));
    feed_q.push_back(value_t'(64'd9));
    feed_q.push_back(value_t'(64'd10));
    feed_q.push_back(value_t'(64'd99));
    feed_q.push_back(value_t'(64'd100));
    feed_q.push_back(value_t'(64'd4294967295));
    feed_q.push_back(value_t'(64'd4294967296));
    feed_q.push_back(value_t'(64'h00000001_00000001));
    feed_q.push_back(value_t'(64'd999999999));
    feed_q.push_back(value_t'(64'd1000000000));
    feed_q.push_back(value_t'(64'd9999999999));
    feed_q.push_back(value_t'(64'd10000000000));
    feed_q.push_back(value_t'(64'd999999999999999999));
    feed_q.push_back(value_t'(64'd9999999999999999999));
    feed_q.push_back(value_t'(64'd10000000000000000000));
    feed_q.push_back(value_t'(64'h80000000_00000000));
    feed_q.push_back(value_t'(64'hFFFFFFFF_00000000));
    feed_q.push_back(value_t'(64'hFFFFFFFF_FFFFFFFF));
    feed_q.push_back(value_t'(64'hFFFFFFFF_FFFFFFFE));
    feed_q.push_back(value_t'(64'h00000000_AAAAAAAA));
    feed_q.push_back(value_t'(64'h55555555_55555555));
    feed_q.push_back(value_t'(64'hAAAAAAAA_AAAAAAAA));
    feed_q.push_back(value_t'(64'h12345678_9ABCDEF0));
    for (int i = 0; i < 450; i++) begin
      case ($urandom_range(0, 3))
        0: r = {$urandom, $urandom};
        1: r = {$urandom, $urandom} >> $urandom_range(0, 63);
        // just around a power of ten, where the digit count changes
        2: r = pow10($urandom_range(0, 19)) - 64'd1 + 64'($urandom_range(0, 2));
        default: r = {$urandom, $urandom} % pow10($urandom_range(1, 19));
      endcase
      feed_q.push_back(value_t'(r));
    end
    total_items = feed_q.size();
    quiet_start = total_items - QUIET_LEN;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items) @(posedge clk);
    while (digits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* binary64_to_decimal_ascii_unit.f */
sv/b64da_pkg.sv
sv/b64da_cell.sv
sv/b64da_emit.sv
sv/binary64_to_decimal_ascii_unit.sv
bench/binary64_to_decimal_ascii_unit_test.sv
